// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the power integrator RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define NPI_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Implication checked in the same cycle.
`define NPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define NPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPI_ASSERT(lbl, clk, rst, cond)
`define NPI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NPI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/npi_pkg.sv =====
// Shared constants and control types of the noncoherent power integrator.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps
`default_nettype none
package npi_pkg;

  // Sizes of the block.
  localparam int MAX_BINS    = 1024;
  localparam int MAX_SWEEPS  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int SWEEP_W     = $clog2(MAX_SWEEPS);
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SUM_W       = 38;
  localparam int POWER_W     = 32;
  localparam int NB_W        = 11;
  localparam int NS_W        = 7;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SWEEPS = 1'd1;
  localparam int CFG_DATA_W = NB_W;

  // Reset values of the registers.
  localparam logic [NB_W-1:0] NUM_BINS_RST   = NB_W'(1024);
  localparam logic [NS_W-1:0] NUM_SWEEPS_RST = NS_W'(16);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture a sample beat and step the bin/sweep counters
    logic mul;        // square the magnitudes
    logic add;        // accumulate and write the bin entry
    logic div_start;  // start the mean division
    logic load_out;   // move the quotient into the output register
  } npi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_sweep; // current item belongs to the last sweep
    logic div_done;   // quotient is ready
    logic out_free;   // output register can take a new beat
  } npi_stat_t;

endpackage
`default_nettype wire

// ===== hdl/npi_if.sv =====
// Handshake channels of the power integrator: samples in, results out,
// and register writes. Depends on npi_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

// Complex sample channel.
interface npi_sample_if;
  logic valid;
  logic ready;
  logic signed [npi_pkg::SAMPLE_BITS-1:0] sample_re;
  logic signed [npi_pkg::SAMPLE_BITS-1:0] sample_im;
  modport source (output valid, sample_re, sample_im, input ready);
  modport sink (input valid, sample_re, sample_im, output ready);
endinterface

// Mean power result channel.
interface npi_result_if;
  logic valid;
  logic ready;
  logic [npi_pkg::POWER_W-1:0] mean_power;
  logic [npi_pkg::BIN_W-1:0]   bin_index;
  logic                        last_bin;
  modport source (output valid, mean_power, bin_index, last_bin, input ready);
  modport sink (input valid, mean_power, bin_index, last_bin, output ready);
endinterface

// Register write channel.
interface npi_cfg_if;
  logic valid;
  logic ready;
  logic [npi_pkg::CFG_IDX_W-1:0]  index;
  logic [npi_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/npi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-bin mean.
// Depends on npi_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module npi_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [npi_pkg::SUM_W-1:0] dividend,
  input  wire logic [npi_pkg::NS_W-1:0]  divisor,
  output logic      [npi_pkg::SUM_W-1:0] quotient,
  output logic                           done
);
  import npi_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [NS_W-1:0]      rem;
  logic [NS_W-1:0]      dsor;
  logic [NS_W:0]        trial;
  logic                 fits;

  // Shift the next dividend bit into the remainder and try a subtract.
  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    fits  = trial >= {1'b0, dsor};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= DIV_CNT_W'(SUM_W - 1);
    end else if (busy) begin
      count <= count - DIV_CNT_W'(1);
      if (count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? NS_W'(trial - {1'b0, dsor}) : trial[NS_W-1:0];
    end
  end

  `NPI_ASSERT(a_busy_done_excl, clk, rst, !(busy && done))
  `NPI_ASSERT_IMP(a_start_idle, clk, rst, start, !busy)
  `NPI_ASSERT_NEXT(a_done_after_last, clk, rst, busy && count == '0 && !start, done)

endmodule
`default_nettype wire

// ===== hdl/npi_ctrl.sv =====
// Controller of the power integrator: sequences accept, square, accumulate,
// divide and output. Depends on npi_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module npi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output npi_pkg::npi_cmd_t       cmd,
  input  wire npi_pkg::npi_stat_t stat
);
  import npi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add       = 1'b1;
        cmd.div_start = stat.last_sweep;
        state_next    = stat.last_sweep ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `NPI_ASSERT_IMP(a_div_only_last, clk, rst, state == S_DIV, stat.last_sweep)
  `NPI_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, stat.out_free)
  `NPI_ASSERT_NEXT(a_accept_to_mul, clk, rst, in_valid && in_ready, state == S_MUL)

endmodule
`default_nettype wire

// ===== hdl/npi_datapath.sv =====
// Datapath of the power integrator: registers, bin/sweep counters, squares,
// accumulator memory, divider and output register. Depends on npi_pkg, npi_div.
`timescale 1ns / 1ps
`default_nettype none
module npi_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire npi_pkg::npi_cmd_t                   cmd,
  output npi_pkg::npi_stat_t                       stat,
  input  wire logic signed [npi_pkg::SAMPLE_BITS-1:0] sample_re,
  input  wire logic signed [npi_pkg::SAMPLE_BITS-1:0] sample_im,
  input  wire logic                                cfg_valid,
  input  wire logic [npi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [npi_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [npi_pkg::POWER_W-1:0]              mean_power,
  output logic [npi_pkg::BIN_W-1:0]                bin_index,
  output logic                                     last_bin
);
  import npi_pkg::*;

  logic [NB_W-1:0]        num_bins;
  logic [NS_W-1:0]        num_sweeps;
  logic [NB_W-1:0]        bins_eff;
  logic [NS_W-1:0]        sweeps_eff;
  logic [BIN_W-1:0]       bin_count;
  logic [SWEEP_W-1:0]     sweep_count;
  logic                   row_end_now;
  logic                   last_now;
  logic [SAMPLE_BITS-1:0] re_bits;
  logic [SAMPLE_BITS-1:0] im_bits;
  logic [SAMPLE_BITS-1:0] mag_re;
  logic [SAMPLE_BITS-1:0] mag_im;
  logic [SQ_W-1:0]        sq_re;
  logic [SQ_W-1:0]        sq_im;
  logic [BIN_W-1:0]       slot;
  logic                   item_first;
  logic                   item_last;
  logic                   item_row_end;
  logic [NS_W-1:0]        item_sweeps;
  logic [SUM_W-1:0]       sum_mem [MAX_BINS];
  logic [SUM_W-1:0]       rd_data;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       quotient;
  logic                   div_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins   <= NUM_BINS_RST;
      num_sweeps <= NUM_SWEEPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_BINS:   num_bins   <= cfg_data;
        REG_NUM_SWEEPS: num_sweeps <= cfg_data[NS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into their usable ranges.
  always_comb begin
    if (num_bins == '0) bins_eff = NB_W'(1);
    else if (num_bins > NB_W'(MAX_BINS)) bins_eff = NB_W'(MAX_BINS);
    else bins_eff = num_bins;
    if (num_sweeps == '0) sweeps_eff = NS_W'(1);
    else if (num_sweeps > NS_W'(MAX_SWEEPS)) sweeps_eff = NS_W'(MAX_SWEEPS);
    else sweeps_eff = num_sweeps;
  end

  // A position at or past the last one wraps.
  assign row_end_now = (NB_W'(bin_count) + NB_W'(1)) >= bins_eff;
  assign last_now    = (NS_W'(sweep_count) + NS_W'(1)) >= sweeps_eff;

  // Bin and sweep position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count   <= '0;
      sweep_count <= '0;
    end else if (cmd.accept) begin
      if (row_end_now) begin
        bin_count   <= '0;
        sweep_count <= last_now ? '0 : sweep_count + SWEEP_W'(1);
      end else begin
        bin_count <= bin_count + BIN_W'(1);
      end
    end
  end

  // Bit patterns of the two's complement parts; magnitudes are taken on capture.
  assign re_bits = sample_re;
  assign im_bits = sample_im;

  // Capture the sample beat and the facts of its position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_re       <= re_bits[SAMPLE_BITS-1] ? (~re_bits + SAMPLE_BITS'(1)) : re_bits;
      mag_im       <= im_bits[SAMPLE_BITS-1] ? (~im_bits + SAMPLE_BITS'(1)) : im_bits;
      slot         <= bin_count;
      item_first   <= sweep_count == '0;
      item_last    <= last_now;
      item_row_end <= row_end_now;
      item_sweeps  <= sweeps_eff;
    end
  end

  // Squares, one multiplier per part.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_re <= SQ_W'(mag_re) * SQ_W'(mag_re);
      sq_im <= SQ_W'(mag_im) * SQ_W'(mag_im);
    end
  end

  // The first sweep starts the bin sum; later sweeps add to it.
  assign sum_next = (item_first ? '0 : rd_data) + SUM_W'(sq_re) + SUM_W'(sq_im);

  // Accumulator memory: read on accept, written back after the add.
  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data <= sum_mem[bin_count];
    if (cmd.add) sum_mem[slot] <= sum_next;
  end

  // Mean over the sweeps.
  npi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_next),
    .divisor  (item_sweeps),
    .quotient (quotient),
    .done     (div_done)
  );

  // Output register; it holds its beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_power <= quotient[POWER_W-1:0];
      bin_index  <= slot;
      last_bin   <= item_row_end;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.last_sweep = item_last;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== hdl/noncoherent_power_integrator_unit.sv =====
// Noncoherent power integrator, top level. Depends on npi_pkg, npi_if,
// npi_ctrl and npi_datapath.
// Each beat on the sample channel is one complex sample. Samples arrive bin
// by bin and sweep by sweep; the block tracks both positions itself. Every
// sweep adds re*re + im*im into the bin's accumulator, the first sweep
// overwriting it. On the last sweep each bin gives one beat on the result
// channel: the truncated mean over the sweeps, its bin index, and a flag on
// the final bin. Registers num_bins and num_sweeps are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Sequence: each item passes the accept, square and accumulate states; an item
// of the last sweep then waits on the one-bit-per-cycle divider over the
// 38-bit sum and goes to the output register. No new sample is taken meanwhile.
// A stalled receiver holds the result in the output register; the block
// takes the next samples meanwhile and waits only when a second result
// is ready to load. Reset clears the position counters and restores the
// registers to 1024 bins and 16 sweeps; accumulators need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module noncoherent_power_integrator_unit (
  input wire logic clk,
  input wire logic rst,
  npi_sample_if.sink   sample,
  npi_result_if.source result,
  npi_cfg_if.sink      cfg
);
  import npi_pkg::*;

  npi_cmd_t  cmd;
  npi_stat_t stat;
  logic      in_ready;

  assign sample.ready = in_ready;
  assign cfg.ready    = 1'b1;

  // Sequencer.
  npi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Arithmetic and storage.
  npi_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_re  (sample.sample_re),
    .sample_im  (sample.sample_im),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .mean_power (result.mean_power),
    .bin_index  (result.bin_index),
    .last_bin   (result.last_bin)
  );

endmodule
`default_nettype wire

// ===== verif/npi_power_checker.sv =====
// Scoreboard for the noncoherent power integrator: follows the bin and sweep
// accumulation on every sample beat and checks each result beat against it.
// Depends on npi_pkg and the channel interfaces in npi_if.
`timescale 1ns / 1ps
module npi_power_checker (
  input  logic  clk,
  input  logic  rst,
  npi_sample_if smp,
  npi_result_if res,
  npi_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding,
  output int    compared
);
  import npi_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [POWER_W-1:0] mean;
    logic [BIN_W-1:0]   bin;
    logic               last;
  } bin_mean_t;

  logic [SUM_W-1:0]   energy [MAX_BINS];
  logic [BIN_W-1:0]   bin_pos;
  logic [SWEEP_W-1:0] sweep_pos;
  logic [NB_W-1:0]    bins_reg;
  logic [NS_W-1:0]    sweeps_reg;
  bin_mean_t          due_means[$];
  int                 bad = 0;
  int                 seen = 0;

  // Out-of-range register values act as the nearest legal one.
  function automatic int span(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic log_mismatch(string what);
    bad++;
    if (bad <= PRINT_CAP) $display("power check at %0t: %s", $realtime, what);
  endtask

  // Accumulate one sample into its bin and queue the mean on the last sweep.
  function automatic void integrate_sample(logic [SAMPLE_BITS-1:0] re,
                                           logic [SAMPLE_BITS-1:0] im);
    int                 nb;
    int                 ns;
    logic [SAMPLE_BITS:0] mag_re;
    logic [SAMPLE_BITS:0] mag_im;
    logic [SUM_W-1:0]   acc;
    logic               final_sweep;
    logic               row_end;
    bin_mean_t          m;
    nb = span(int'(bins_reg), MAX_BINS);
    ns = span(int'(sweeps_reg), MAX_SWEEPS);
    mag_re = re[SAMPLE_BITS-1] ? -{1'b1, re} : {1'b0, re};
    mag_im = im[SAMPLE_BITS-1] ? -{1'b1, im} : {1'b0, im};
    acc = SUM_W'(mag_re) * SUM_W'(mag_re) + SUM_W'(mag_im) * SUM_W'(mag_im);
    // The first sweep overwrites the bin; later sweeps add to it.
    if (sweep_pos != '0) acc = acc + energy[bin_pos];
    energy[bin_pos] = acc;
    final_sweep = int'(sweep_pos) + 1 >= ns;
    row_end = int'(bin_pos) + 1 >= nb;
    if (final_sweep) begin
      m.mean = POWER_W'(acc / SUM_W'(ns));
      m.bin = bin_pos;
      m.last = row_end;
      due_means.push_back(m);
    end
    // Positions at or past the end of the row or integration wrap to zero.
    if (row_end) begin
      bin_pos = '0;
      sweep_pos = final_sweep ? '0 : sweep_pos + 1'b1;
    end else begin
      bin_pos = bin_pos + 1'b1;
    end
  endfunction

  task automatic check_result();
    bin_mean_t want;
    if (due_means.size() == 0) begin
      log_mismatch($sformatf("result beat with nothing due: bin %0d power %0d",
                             res.bin_index, res.mean_power));
      return;
    end
    want = due_means.pop_front();
    seen++;
    if (res.mean_power !== want.mean)
      log_mismatch($sformatf("bin %0d mean_power %0d, want %0d",
                             want.bin, res.mean_power, want.mean));
    if (res.bin_index !== want.bin)
      log_mismatch($sformatf("bin_index %0d, want %0d", res.bin_index, want.bin));
    if (res.last_bin !== want.last)
      log_mismatch($sformatf("bin %0d last_bin %0b, want %0b",
                             want.bin, res.last_bin, want.last));
  endtask

  // Register writes, sample beats and result beats, in that order per edge.
  always @(posedge clk) begin
    if (rst) begin
      bin_pos = '0;
      sweep_pos = '0;
      bins_reg = NUM_BINS_RST;
      sweeps_reg = NUM_SWEEPS_RST;
      due_means.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NUM_BINS:   bins_reg = cfg.data[NB_W-1:0];
          REG_NUM_SWEEPS: sweeps_reg = cfg.data[NS_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) integrate_sample(smp.sample_re, smp.sample_im);
      if (res.valid && res.ready) check_result();
    end
    mismatches <= bad;
    outstanding <= due_means.size();
    compared <= seen;
  end

endmodule

// ===== verif/noncoherent_power_integrator_unit_test.sv =====
// Testbench top for noncoherent_power_integrator_unit: drives samples and
// register writes, throttles the result channel, and gives the verdict.
// Depends on npi_pkg, npi_if, npi_power_checker and the block itself.
`timescale 1ns / 1ps
module noncoherent_power_integrator_unit_test;
  import npi_pkg::*;

  localparam int     HALF_PERIOD    = 10;
  localparam int     SETTLE_CYCLES  = 60;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     MODE_SAMPLES   = 110;
  localparam longint TIMEOUT_NS     = 64'd10_000_000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_NEG1 = 16'shFFFF;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   compared;

  npi_sample_if smp();
  npi_result_if res();
  npi_cfg_if    cfg_bus();

  noncoherent_power_integrator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_bus)
  );

  npi_power_checker power_check (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .cfg         (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  // Stimulus-side view of the block: register values and bin/sweep position.
  logic [NB_W-1:0] reg_bins;
  logic [NS_W-1:0] reg_sweeps;
  int              pos_bin;
  int              pos_sweep;
  int              src_gap_pct;
  int              sink_stall_pct;
  bit              hold_toggle;
  int              samples_sent;
  int              settings_used;

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  function automatic int span(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Result receiver: random stalls, or a long hold-off whenever the toggle flips.
  initial begin
    int hold_left;
    bit seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Send one sample beat, with random gaps ahead of it.
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im);
    int nb;
    int ns;
    while ($urandom_range(99) < src_gap_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_re <= re;
    smp.sample_im <= im;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    samples_sent++;
    nb = span(int'(reg_bins), MAX_BINS);
    ns = span(int'(reg_sweeps), MAX_SWEEPS);
    if (pos_bin + 1 >= nb) begin
      pos_bin = 0;
      pos_sweep = (pos_sweep + 1 >= ns) ? 0 : pos_sweep + 1;
    end else begin
      pos_bin++;
    end
  endtask

  // Stop offering, wait for every due result, then let the divider drain.
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid drops only after the second beat.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] bins_word,
                          input logic [CFG_DATA_W-1:0] sweeps_word);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_NUM_BINS;
    cfg_bus.data <= bins_word;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.index <= REG_NUM_SWEEPS;
    cfg_bus.data <= sweeps_word;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    reg_bins = bins_word[NB_W-1:0];
    reg_sweeps = sweeps_word[NS_W-1:0];
    settings_used++;
  endtask

  // Mostly extremes and full-range values; a loud run is all full-scale.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_part(bit loud);
    if (loud) return S_MIN;
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return S_NEG1;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Finish the integration under way, then run k whole ones.
  task automatic run_integrations(int k, bit loud);
    while (pos_bin != 0 || pos_sweep != 0) push_sample(pick_part(loud), pick_part(loud));
    repeat (k) begin
      push_sample(pick_part(loud), pick_part(loud));
      while (pos_bin != 0 || pos_sweep != 0) push_sample(pick_part(loud), pick_part(loud));
    end
  endtask

  // One random register setting followed by whole or cut-short integrations.
  task automatic random_phase();
    logic [CFG_DATA_W-1:0] bins_word;
    logic [CFG_DATA_W-1:0] sweeps_word;
    bit                    loud;
    int                    whole;
    loud = 1'b0;
    case ($urandom_range(9))
      0: begin
        bins_word = CFG_DATA_W'($urandom_range(1));
        sweeps_word = CFG_DATA_W'($urandom_range(40, 127));
        loud = 1'($urandom_range(1));
      end
      1: begin
        bins_word = CFG_DATA_W'($urandom_range(1, 4));
        sweeps_word = CFG_DATA_W'($urandom_range(1));
      end
      default: begin
        bins_word = CFG_DATA_W'($urandom_range(1, 8));
        sweeps_word = CFG_DATA_W'($urandom_range(2, 6));
      end
    endcase
    // Bits above the sweep register's width are ignored by the block.
    sweeps_word[CFG_DATA_W-1:NS_W] = 4'($urandom_range(15));
    // Past the first sweep, a longer row would read bins this integration never wrote.
    if (pos_sweep != 0 && span(int'(bins_word), MAX_BINS) > span(int'(reg_bins), MAX_BINS))
      bins_word = CFG_DATA_W'(reg_bins);
    set_regs(bins_word, sweeps_word);
    if ($urandom_range(4) == 0) begin
      whole = span(int'(bins_word), MAX_BINS) * span(int'(sweeps_word[NS_W-1:0]), MAX_SWEEPS);
      repeat ($urandom_range(1, whole)) push_sample(pick_part(loud), pick_part(loud));
    end else begin
      run_integrations($urandom_range(1, 2), loud);
    end
  endtask

  // Main sequence: directed cases, three modes of sender gaps and receiver stalls, then pressure.
  initial begin
    int start;
    int mode;
    rst <= 1'b1;
    smp.valid <= 1'b0;
    smp.sample_re <= '0;
    smp.sample_im <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_NUM_BINS;
    cfg_bus.data <= '0;
    sink_stall_pct <= 0;
    hold_toggle <= 1'b0;
    src_gap_pct = 0;
    reg_bins = NUM_BINS_RST;
    reg_sweeps = NUM_SWEEPS_RST;
    pos_bin = 0;
    pos_sweep = 0;
    samples_sent = 0;
    settings_used = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a few first-sweep samples, so no results yet.
    push_sample(S_MAX, S_MIN);
    push_sample(S_MIN, S_MAX);
    push_sample('0, '0);
    settle();

    // Row shrunk below the current bin: that bin closes the row at once.
    // With a single sweep every bin reports its own power.
    set_regs(11'd2, 11'd1);
    push_sample(S_MIN, S_MIN);
    push_sample(S_MAX, S_MAX);
    push_sample(S_NEG1, 16'sd1);
    push_sample(16'sd1, S_NEG1);
    push_sample('0, S_MIN);
    push_sample(S_MIN, '0);
    settle();

    // Zero in both registers acts as one bin and one sweep.
    set_regs(11'd0, 11'd0);
    push_sample(16'sd12345, -16'sd12345);
    push_sample(S_MIN, S_MIN);
    push_sample(16'sd7, '0);
    settle();

    // Two sweeps over three bins: odd sums truncate, full scale sums to 2^32.
    set_regs(11'd3, 11'd2);
    push_sample(16'sd1, '0);
    push_sample(S_MIN, S_MIN);
    push_sample(16'sd3, 16'sd4);
    push_sample('0, '0);
    push_sample(S_MIN, S_MIN);
    push_sample(16'sd1, 16'sd1);
    settle();

    // Values above the limits clamp; then a shrink closes the integration early.
    set_regs(11'd2047, 11'd127);
    push_sample(S_MAX, '0);
    push_sample(-16'sd300, 16'sd200);
    settle();
    set_regs(11'd1, 11'd1);
    push_sample(S_MIN, S_MAX);
    settle();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_gap_pct = 16; sink_stall_pct <= 54; end
        1: begin src_gap_pct = 54; sink_stall_pct <= 16; end
        default: begin src_gap_pct = 0; sink_stall_pct <= 0; end
      endcase
      start = samples_sent;
      while (samples_sent - start < MODE_SAMPLES) begin
        settle();
        random_phase();
      end
    end

    // Long receiver hold while samples keep coming: the input must back up.
    run_integrations(0, 1'b0);
    settle();
    set_regs(11'd8, 11'd1);
    hold_toggle <= ~hold_toggle;
    repeat (40) push_sample(pick_part(1'b0), pick_part(1'b0));
    settle();

    $display("Summary: %0d samples under %0d register settings, %0d mean powers checked.",
             samples_sent, settings_used, compared);
    $display("Covered clamped and mid-integration settings, sender and receiver gaps, %s",
             "and a long receiver hold.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: results or handshakes stopped arriving.");
    $display("Some tests failed");
    $finish;
  end

endmodule
